### rtl/dfat_pkg.sv
package dfat_pkg;

  // Message layout
  localparam logic [3:0] HDR_LEN   = 4'd12;
  localparam logic [7:0] PTR_MASK  = 8'hC0;
  localparam logic [7:0] LABEL_MAX = 8'd63;
  localparam logic [2:0] FIELD_LEN = 3'd4;
  localparam logic [3:0] ANS_MIN   = 4'd10;

  // Configuration port
  localparam int unsigned   CFG_ADDR_W     = 3;
  localparam int unsigned   CFG_DATA_W     = 32;
  localparam logic [31:0]   FALLBACK_RESET = 32'd60;
  // Register index sits in paddr[2]; byte lanes below it are ignored
  localparam logic          REG_FALLBACK   = 1'b0;

  typedef struct packed {
    logic [31:0] ttl;
    logic        used_fallback;
  } dfat_result_t;

endpackage

### rtl/dns_first_answer_ttl_extractor.sv
// DNS first-answer TTL extractor.
// Input channel (in_valid/in_ready): one message byte per word, in_last_byte
// set on the final byte. The block walks header, question and answer name and
// captures the first answer's TTL. Every message yields exactly one result
// word (out_valid/out_ready) on its final byte: out_ttl with
// out_used_fallback clear, or the fallback TTL with out_used_fallback set
// when the message is malformed, truncated or has too short an answer.
// Throughput: one byte per cycle while no final byte waits on a held result;
// each byte passes an input register, a small state update and, for the
// final byte, the result register, which drives out_valid once loaded.
// Stall: a held result blocks only the next final byte; ordinary bytes keep
// flowing, and in_ready drops only once a final byte waits behind the result.
// Reset (rst_n, synchronous): parse state and both valid flags clear, the
// fallback TTL returns to 60. The fallback register sits at byte address 0
// of the cfg_ port and should be written only while no message is in flight.
module dns_first_answer_ttl_extractor
  import dfat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_ttl,
  output logic                  out_used_fallback,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [31:0]  fallback_ttl;
  logic         res_valid;
  logic         res_ready;
  dfat_result_t res;
  dfat_result_t out_res;

  dfat_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .fallback_ttl (fallback_ttl)
  );

  dfat_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_data_byte),
    .in_last      (in_last_byte),
    .fallback_ttl (fallback_ttl),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  dfat_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_ttl           = out_res.ttl;
  assign out_used_fallback = out_res.used_fallback;

endmodule

### rtl/dfat_cfg.sv
module dfat_cfg
  import dfat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [31:0]           fallback_ttl
);

  logic [31:0] fallback_r;
  logic        hit;

  assign hit          = (paddr[2] == REG_FALLBACK);
  assign pready       = 1'b1;
  assign prdata       = hit ? fallback_r : '0;
  assign fallback_ttl = fallback_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= FALLBACK_RESET;
    end else if (psel && penable && pwrite && hit) begin
      fallback_r <= pwdata;
    end
  end

endmodule

### rtl/dfat_parser.sv
module dfat_parser
  import dfat_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  input  logic [31:0]  fallback_ttl,
  output logic         res_valid,
  input  logic         res_ready,
  output dfat_result_t res
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_QLEN, PH_QLABEL, PH_QPTR, PH_QFIXED, PH_AFIRST,
    PH_ALEN, PH_ALABEL, PH_APTR, PH_ATYPECLASS, PH_TTL, PH_DONE
  } phase_t;

  // Input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        consume;

  // Parse state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [5:0]  label_left_r, label_left_nxt;
  logic [2:0]  field_left_r, field_left_nxt;
  logic [3:0]  aq_cnt_r, aq_cnt_nxt;
  logic [31:0] ttl_shift_r, ttl_shift_nxt;
  logic        failed_r, failed_nxt;
  logic        ok;

  assign consume   = s1_valid_r && (!s1_last_r || res_ready);
  assign in_ready  = !s1_valid_r || consume;
  assign res_valid = s1_valid_r && s1_last_r;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    label_left_nxt = label_left_r;
    field_left_nxt = field_left_r;
    aq_cnt_nxt     = aq_cnt_r;
    ttl_shift_nxt  = ttl_shift_r;
    failed_nxt     = failed_r;

    if (!failed_r) begin
      if ((phase_r inside {[PH_AFIRST:PH_DONE]}) && (aq_cnt_r < ANS_MIN)) begin
        aq_cnt_nxt = aq_cnt_r + 4'd1;
      end
      case (phase_r)
        PH_HEADER: begin
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          if (hdr_cnt_nxt >= HDR_LEN) begin
            phase_nxt = PH_QLEN;
          end
        end
        PH_QLEN: begin
          if ((s1_byte_r & PTR_MASK) == PTR_MASK) begin
            phase_nxt = PH_QPTR;
          end else if (s1_byte_r == 8'd0) begin
            phase_nxt      = PH_QFIXED;
            field_left_nxt = FIELD_LEN;
          end else if (s1_byte_r > LABEL_MAX) begin
            failed_nxt = 1'b1;
          end else begin
            label_left_nxt = s1_byte_r[5:0];
            phase_nxt      = PH_QLABEL;
          end
        end
        PH_QLABEL: begin
          label_left_nxt = label_left_r - 6'd1;
          if (label_left_nxt == 6'd0) begin
            phase_nxt = PH_QLEN;
          end
        end
        PH_QPTR: begin
          phase_nxt      = PH_QFIXED;
          field_left_nxt = FIELD_LEN;
        end
        PH_QFIXED: begin
          field_left_nxt = field_left_r - 3'd1;
          if (field_left_nxt == 3'd0) begin
            phase_nxt = PH_AFIRST;
          end
        end
        PH_AFIRST, PH_ALEN: begin
          // Pointer form is only legal as the first byte of the answer name
          if ((phase_r == PH_AFIRST) && ((s1_byte_r & PTR_MASK) == PTR_MASK)) begin
            phase_nxt = PH_APTR;
          end else if (s1_byte_r == 8'd0) begin
            phase_nxt      = PH_ATYPECLASS;
            field_left_nxt = FIELD_LEN;
          end else if (s1_byte_r > LABEL_MAX) begin
            failed_nxt = 1'b1;
          end else begin
            label_left_nxt = s1_byte_r[5:0];
            phase_nxt      = PH_ALABEL;
          end
        end
        PH_ALABEL: begin
          label_left_nxt = label_left_r - 6'd1;
          if (label_left_nxt == 6'd0) begin
            phase_nxt = PH_ALEN;
          end
        end
        PH_APTR: begin
          phase_nxt      = PH_ATYPECLASS;
          field_left_nxt = FIELD_LEN;
        end
        PH_ATYPECLASS: begin
          field_left_nxt = field_left_r - 3'd1;
          if (field_left_nxt == 3'd0) begin
            phase_nxt      = PH_TTL;
            field_left_nxt = FIELD_LEN;
            ttl_shift_nxt  = '0;
          end
        end
        PH_TTL: begin
          ttl_shift_nxt  = {ttl_shift_r[23:0], s1_byte_r};
          field_left_nxt = field_left_r - 3'd1;
          if (field_left_nxt == 3'd0) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
          // trailing bytes are ignored
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  assign ok = !failed_nxt && (phase_nxt == PH_DONE) && (aq_cnt_nxt >= ANS_MIN);
  assign res.ttl           = ok ? ttl_shift_nxt : fallback_ttl;
  assign res.used_fallback = !ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (consume && s1_last_r)) begin
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= '0;
      label_left_r <= '0;
      field_left_r <= '0;
      aq_cnt_r     <= '0;
      ttl_shift_r  <= '0;
      failed_r     <= 1'b0;
    end else if (consume) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      label_left_r <= label_left_nxt;
      field_left_r <= field_left_nxt;
      aq_cnt_r     <= aq_cnt_nxt;
      ttl_shift_r  <= ttl_shift_nxt;
      failed_r     <= failed_nxt;
    end
  end

endmodule

### rtl/dfat_out_reg.sv
module dfat_out_reg
  import dfat_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_valid,
  output logic         res_ready,
  input  dfat_result_t res,
  output logic         out_valid,
  input  logic         out_ready,
  output dfat_result_t out_res
);

  logic         valid_r;
  dfat_result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule

### rtl/dfat_checker.sv
module dfat_checker
  import dfat_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [7:0]            in_data_byte,
  input logic                  in_last_byte,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [31:0]           out_ttl,
  input logic                  out_used_fallback,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  // A waiting input word keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) && $stable(in_last_byte))
    else $error("input word changed or dropped while waiting");

  // A held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ttl) && $stable(out_used_fallback))
    else $error("result word changed or dropped while stalled");

  // Nothing emerges straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid just after reset");

  // With the result register empty the input side never stalls
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Fallback register reads back what was just written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]
    |=> (cfg_psel && !cfg_pwrite && !cfg_paddr[2]) ->
        (cfg_prdata == $past(cfg_pwdata)))
    else $error("fallback register readback mismatch");

endmodule

bind dns_first_answer_ttl_extractor dfat_checker u_dfat_checker (.*);
